>>> rtl/cbmd_pkg.sv
package cbmd_pkg;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TRIES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NMI_MIN    = 2'd2;

    localparam logic [15:0] ACK_TRIES_RST  = 16'd1000;
    localparam logic [15:0] HOLD_TICKS_RST = 16'd100;
    localparam logic [7:0]  NMI_MIN_RST    = 8'd1;

    localparam logic [2:0] OP_NONE     = 3'd0;
    localparam logic [2:0] OP_ACQUIRE  = 3'd1;
    localparam logic [2:0] OP_RELEASE  = 3'd2;
    localparam logic [2:0] OP_REL_NMI  = 3'd3;
    localparam logic [2:0] OP_MEM_RD   = 3'd4;
    localparam logic [2:0] OP_MEM_WR   = 3'd5;
    localparam logic [2:0] OP_IO_RD    = 3'd6;
    localparam logic [2:0] OP_IO_WR    = 3'd7;

    localparam logic [1:0] STATUS_NONE    = 2'd0;
    localparam logic [1:0] STATUS_OK      = 2'd1;
    localparam logic [1:0] STATUS_ALREADY = 2'd2;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        bus_ack;
        logic [7:0]  bus_data;
    } in_item_t;

    typedef struct packed {
        logic        bus_req;
        logic        rd_n;
        logic        wr_n;
        logic        mreq_n;
        logic        iorq_n;
        logic        nmi;
        logic [15:0] addr_out;
        logic [7:0]  drive_byte;
        logic        data_drive;
        logic [7:0]  rdata;
        logic [1:0]  status;
        logic        busy_res;
    } out_item_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_wr_t;

endpackage

>>> rtl/cpu_bus_master_dma_cycles_unit.sv
// data path: input register, then result register
// throughput: one transaction per cycle while the output is not stalled, set by
// the single-pass state update
// reset: rst_n clears both stages, the bus state and the registers to their
// defaults (ack_tries 1000, hold_ticks 100, nmi_min_ticks 1), strobes high
module cpu_bus_master_dma_cycles_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [cbmd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cbmd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // op[2:0], addr[18:3], wdata[26:19], bus_ack[27], bus_data[35:28], zero pad
    input  logic [cbmd_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // bus_req[0], rd_n[1], wr_n[2], mreq_n[3], iorq_n[4], nmi[5], addr_out[21:6],
    // drive_byte[29:22], data_drive[30], rdata[38:31], status[40:39], busy_res[41]
    output logic [cbmd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

    logic                 in_valid_reg;
    cbmd_pkg::in_item_t   in_item_reg;
    logic                 out_valid_reg;
    cbmd_pkg::out_item_t  out_item_reg;
    cbmd_pkg::out_item_t  result;
    cbmd_pkg::cfg_wr_t    cfg;
    logic                 step;

    assign cfg = {cfg_we, cfg_index, cfg_wdata};

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.op       <= s_axis_tdata[2:0];
            in_item_reg.addr     <= s_axis_tdata[18:3];
            in_item_reg.wdata    <= s_axis_tdata[26:19];
            in_item_reg.bus_ack  <= s_axis_tdata[27];
            in_item_reg.bus_data <= s_axis_tdata[35:28];
        end
    end

    cbmd_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .item   (in_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || m_axis_tready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_item_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0,
                            out_item_reg.busy_res,
                            out_item_reg.status,
                            out_item_reg.rdata,
                            out_item_reg.data_drive,
                            out_item_reg.drive_byte,
                            out_item_reg.addr_out,
                            out_item_reg.nmi,
                            out_item_reg.iorq_n,
                            out_item_reg.mreq_n,
                            out_item_reg.wr_n,
                            out_item_reg.rd_n,
                            out_item_reg.bus_req};

endmodule

>>> rtl/cbmd_core.sv
module cbmd_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  cbmd_pkg::cfg_wr_t  cfg,
    input  logic               step,
    input  cbmd_pkg::in_item_t item,
    output cbmd_pkg::out_item_t result
);

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_ACQ      = 3'd1;
    localparam logic [2:0] PH_REL      = 3'd2;
    localparam logic [2:0] PH_NMI_MIN  = 3'd3;
    localparam logic [2:0] PH_NMI_WAIT = 3'd4;
    localparam logic [2:0] PH_NMI_TAIL = 3'd5;
    localparam logic [2:0] PH_CYCLE    = 3'd6;

    // strobe bit order: rd_n, wr_n, mreq_n, iorq_n
    localparam logic [3:0] STROBE_IDLE = 4'b1111;

    logic [15:0] ack_tries_reg;
    logic [15:0] hold_ticks_reg;
    logic [7:0]  nmi_min_reg;

    logic        owned_reg,   owned_next;
    logic [2:0]  phase_reg,   phase_next;
    logic [15:0] tick_reg,    tick_next;
    logic        kind_wr_reg, kind_wr_next;
    logic [3:0]  strobe_reg,  strobe_next;
    logic        req_reg,     req_next;
    logic        nmi_reg,     nmi_next;
    logic [15:0] addr_reg,    addr_next;
    logic [7:0]  wdata_reg,   wdata_next;
    logic [7:0]  rbyte_reg,   rbyte_next;
    logic [1:0]  status;

    logic [15:0] tick_inc;
    logic [15:0] hold_min;
    logic [15:0] nmi_min;
    logic        drive;

    assign tick_inc = tick_reg + 16'd1;
    assign hold_min = (hold_ticks_reg == 16'd0) ? 16'd1 : hold_ticks_reg;
    assign nmi_min  = (nmi_min_reg == 8'd0) ? 16'd1 : {8'd0, nmi_min_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_tries_reg  <= cbmd_pkg::ACK_TRIES_RST;
            hold_ticks_reg <= cbmd_pkg::HOLD_TICKS_RST;
            nmi_min_reg    <= cbmd_pkg::NMI_MIN_RST;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                cbmd_pkg::CFG_ACK_TRIES:  ack_tries_reg  <= cfg.wdata;
                cbmd_pkg::CFG_HOLD_TICKS: hold_ticks_reg <= cfg.wdata;
                cbmd_pkg::CFG_NMI_MIN:    nmi_min_reg    <= cfg.wdata[7:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        owned_next   = owned_reg;
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        kind_wr_next = kind_wr_reg;
        strobe_next  = strobe_reg;
        req_next     = req_reg;
        nmi_next     = nmi_reg;
        addr_next    = addr_reg;
        wdata_next   = wdata_reg;
        rbyte_next   = rbyte_reg;
        status       = cbmd_pkg::STATUS_NONE;

        case (phase_reg)
            PH_IDLE:
            begin
                case (item.op)
                    cbmd_pkg::OP_ACQUIRE:
                    begin
                        if (owned_reg && item.bus_ack)
                        begin
                            status = cbmd_pkg::STATUS_ALREADY;
                        end
                        else if (ack_tries_reg == 16'd0)
                        begin
                            req_next = 1'b0;
                            status   = cbmd_pkg::STATUS_TIMEOUT;
                        end
                        else
                        begin
                            req_next   = 1'b1;
                            tick_next  = 16'd0;
                            phase_next = PH_ACQ;
                        end
                    end
                    cbmd_pkg::OP_RELEASE:
                    begin
                        if (!owned_reg && !item.bus_ack)
                        begin
                            status = cbmd_pkg::STATUS_ALREADY;
                        end
                        else if (ack_tries_reg == 16'd0)
                        begin
                            req_next = 1'b1;
                            status   = cbmd_pkg::STATUS_TIMEOUT;
                        end
                        else
                        begin
                            req_next   = 1'b0;
                            tick_next  = 16'd0;
                            phase_next = PH_REL;
                        end
                    end
                    cbmd_pkg::OP_REL_NMI:
                    begin
                        nmi_next   = 1'b1;
                        req_next   = 1'b0;
                        tick_next  = 16'd0;
                        phase_next = PH_NMI_MIN;
                    end
                    cbmd_pkg::OP_MEM_RD, cbmd_pkg::OP_MEM_WR,
                    cbmd_pkg::OP_IO_RD, cbmd_pkg::OP_IO_WR:
                    begin
                        addr_next    = item.addr;
                        wdata_next   = item.wdata;
                        kind_wr_next = item.op[0];
                        strobe_next  = STROBE_IDLE;
                        if (item.op[0])
                            strobe_next[1] = 1'b0;
                        else
                            strobe_next[0] = 1'b0;
                        if (item.op[1])
                            strobe_next[3] = 1'b0;
                        else
                            strobe_next[2] = 1'b0;
                        tick_next  = 16'd0;
                        phase_next = PH_CYCLE;
                    end
                    default: ;
                endcase
            end
            PH_ACQ, PH_REL:
            begin
                tick_next = tick_inc;
                if (item.bus_ack == (phase_reg == PH_ACQ))
                begin
                    owned_next = (phase_reg == PH_ACQ);
                    status     = cbmd_pkg::STATUS_OK;
                    phase_next = PH_IDLE;
                end
                else if (tick_inc >= ack_tries_reg)
                begin
                    req_next   = (phase_reg != PH_ACQ);
                    status     = cbmd_pkg::STATUS_TIMEOUT;
                    phase_next = PH_IDLE;
                end
            end
            PH_NMI_MIN:
            begin
                tick_next = tick_inc;
                if (tick_inc >= nmi_min)
                begin
                    if (!item.bus_ack)
                    begin
                        nmi_next   = 1'b0;
                        owned_next = 1'b0;
                        phase_next = PH_IDLE;
                        status     = cbmd_pkg::STATUS_OK;
                    end
                    else
                    begin
                        phase_next = PH_NMI_WAIT;
                    end
                end
            end
            PH_NMI_WAIT:
            begin
                if (!item.bus_ack)
                begin
                    tick_next  = 16'd0;
                    phase_next = PH_NMI_TAIL;
                end
            end
            PH_NMI_TAIL:
            begin
                tick_next = tick_inc;
                if (tick_inc >= nmi_min)
                begin
                    nmi_next   = 1'b0;
                    owned_next = 1'b0;
                    phase_next = PH_IDLE;
                    status     = cbmd_pkg::STATUS_OK;
                end
            end
            PH_CYCLE:
            begin
                tick_next = tick_inc;
                if (tick_inc >= hold_min)
                begin
                    if (!kind_wr_reg)
                        rbyte_next = item.bus_data;
                    strobe_next = STROBE_IDLE;
                    status      = cbmd_pkg::STATUS_OK;
                    phase_next  = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owned_reg   <= 1'b0;
            phase_reg   <= PH_IDLE;
            tick_reg    <= 16'd0;
            kind_wr_reg <= 1'b0;
            strobe_reg  <= STROBE_IDLE;
            req_reg     <= 1'b0;
            nmi_reg     <= 1'b0;
            addr_reg    <= 16'd0;
            wdata_reg   <= 8'd0;
            rbyte_reg   <= 8'd0;
        end
        else if (step)
        begin
            owned_reg   <= owned_next;
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            kind_wr_reg <= kind_wr_next;
            strobe_reg  <= strobe_next;
            req_reg     <= req_next;
            nmi_reg     <= nmi_next;
            addr_reg    <= addr_next;
            wdata_reg   <= wdata_next;
            rbyte_reg   <= rbyte_next;
        end
    end

    assign drive = (phase_next == PH_CYCLE) && kind_wr_next;

    always_comb
    begin
        result.bus_req    = req_next;
        result.rd_n       = strobe_next[0];
        result.wr_n       = strobe_next[1];
        result.mreq_n     = strobe_next[2];
        result.iorq_n     = strobe_next[3];
        result.nmi        = nmi_next;
        result.addr_out   = (phase_next == PH_CYCLE) ? addr_next : 16'd0;
        result.drive_byte = drive ? wdata_next : 8'd0;
        result.data_drive = drive;
        result.rdata      = rbyte_next;
        result.status     = status;
        result.busy_res   = (phase_next != PH_IDLE);
    end

endmodule
